// ===== rtl/uvsg_pkg.sv =====
// Shared types, constants and helpers of the UV sphere quad generator.
package uvsg_pkg;

  localparam int CNT_W = 9;
  localparam int IDX_W = 8;
  localparam int POS_W = 16;
  localparam int VNUM_W = 18;

  // Configuration register indexes
  localparam logic [1:0] CFG_U_SEGMENTS = 2'd0;
  localparam logic [1:0] CFG_V_SEGMENTS = 2'd1;

  localparam logic [CNT_W-1:0] SEG_RESET = 9'd16;

  localparam int QUEUE_DEPTH = 2;

  // Phase divider: 44 dividend bits, four bits a stage
  localparam int DIV_BITS = 44;
  localparam int DIV_STEPS_PER_STAGE = 4;
  localparam int DIV_STAGES = DIV_BITS / DIV_STEPS_PER_STAGE;

  localparam int CORDIC_STEPS = 24;
  localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;
  localparam logic signed [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756, 32'sd42667331,
    32'sd21354465, 32'sd10679838, 32'sd5340245, 32'sd2670163, 32'sd1335087,
    32'sd667544, 32'sd333772, 32'sd166886, 32'sd83443, 32'sd41722, 32'sd20861,
    32'sd10430, 32'sd5215, 32'sd2608, 32'sd1304, 32'sd652, 32'sd326, 32'sd163,
    32'sd81
  };

  // Lane: divider stages, CORDIC entry, CORDIC steps, quadrant turn
  localparam int LANE_LAT = DIV_STAGES + CORDIC_STEPS + 2;
  // Plus product and rounding stages
  localparam int PIPE_LAT = LANE_LAT + 2;

  localparam logic signed [19:0] Q14_ONE = 20'sd16384;

  typedef struct packed {
    logic [IDX_W-1:0] i;
    logic [IDX_W-1:0] j;
    logic [CNT_W-1:0] uc;
    logic [CNT_W-1:0] vc;
    logic             err;
    logic             shade;
    logic [15:0]      vbase;
  } item_t;

  typedef struct packed {
    logic              shade;
    logic [VNUM_W-1:0] vnum;
    logic [1:0]        corner;
    logic              err;
    logic              last;
  } meta_t;

  function automatic logic signed [POS_W-1:0] sat_q14(input logic signed [19:0] v);
    logic signed [POS_W-1:0] r;
    if (v > Q14_ONE) r = 16'sd16384;
    else if (v < -Q14_ONE) r = -16'sd16384;
    else r = v[POS_W-1:0];
    return r;
  endfunction

endpackage

// ===== rtl/uvsg_front.sv =====
// Front end: configuration registers, request checks and queue word build.
module uvsg_front #(
  parameter int MAX_U_SEGMENTS = 256,
  parameter int MAX_V_SEGMENTS = 256
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [7:0]              u_index,
  input  logic [7:0]              v_index,
  input  logic                    cfg_valid,
  input  logic [1:0]              cfg_index,
  input  logic [8:0]              cfg_data,
  input  logic                    full,
  output logic                    push,
  output uvsg_pkg::item_t         word
);
  import uvsg_pkg::*;

  logic [CNT_W-1:0] u_segments;
  logic [CNT_W-1:0] v_segments;
  logic [CNT_W-1:0] uc;
  logic [CNT_W-1:0] vc;
  logic             cnt_err;
  logic [16:0]      lin;

  always_ff @(posedge clk) begin
    if (rst) begin
      u_segments <= SEG_RESET;
      v_segments <= SEG_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_U_SEGMENTS) u_segments <= cfg_data;
      if (cfg_index == CFG_V_SEGMENTS) v_segments <= cfg_data;
    end
  end

  // Clamp the counts into the supported range
  always_comb begin
    cnt_err = 1'b0;
    uc = u_segments;
    vc = v_segments;
    if (u_segments == '0) begin
      uc = 9'd1;
      cnt_err = 1'b1;
    end else if (32'(u_segments) > MAX_U_SEGMENTS) begin
      uc = CNT_W'(MAX_U_SEGMENTS);
      cnt_err = 1'b1;
    end
    if (v_segments == '0) begin
      vc = 9'd1;
      cnt_err = 1'b1;
    end else if (32'(v_segments) > MAX_V_SEGMENTS) begin
      vc = CNT_W'(MAX_V_SEGMENTS);
      cnt_err = 1'b1;
    end
  end

  assign lin = 17'(u_index * vc) + 17'(v_index);
  assign push = start && !full;

  always_comb begin
    word.i     = u_index;
    word.j     = v_index;
    word.uc    = uc;
    word.vc    = vc;
    word.err   = cnt_err || ({1'b0, u_index} >= uc) || ({1'b0, v_index} >= vc);
    // set when i*(vc+1)+j is even
    word.shade = ~((u_index[0] & ~vc[0]) ^ v_index[0]);
    word.vbase = lin[15:0];
  end

endmodule

// ===== rtl/uvsg_queue.sv =====
// Short request queue between front end and back end.
module uvsg_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  uvsg_pkg::item_t wr_word,
  input  logic            pop,
  output uvsg_pkg::item_t rd_word,
  output logic            nonempty,
  output logic            full
);
  import uvsg_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

  item_t             store [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_QW-1:0] count;

  assign nonempty = (count != '0);
  assign full = (count == CNT_QW'(QUEUE_DEPTH));
  assign rd_word = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) store[wr_ptr] <= wr_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop) rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

// ===== rtl/uvsg_lane.sv =====
// One angle lane: pipelined phase divider followed by a pipelined CORDIC.
module uvsg_lane (
  input  logic               clk,
  input  logic [8:0]         num,
  input  logic [9:0]         den,
  output logic signed [32:0] cos_val,
  output logic signed [32:0] sin_val
);
  import uvsg_pkg::*;

  typedef struct packed {
    logic [9:0]          rem;
    logic [DIV_BITS-1:0] bits;
    logic [31:0]         quot;
  } div_t;

  function automatic div_t div_step(input div_t cur, input logic [9:0] d);
    div_t       nxt;
    logic [10:0] r2;
    nxt = cur;
    for (int t = 0; t < DIV_STEPS_PER_STAGE; t++) begin
      r2 = {nxt.rem, nxt.bits[DIV_BITS-1]};
      nxt.bits = {nxt.bits[DIV_BITS-2:0], 1'b0};
      if (r2 >= {1'b0, d}) begin
        nxt.rem  = 10'(r2 - {1'b0, d});
        nxt.quot = {nxt.quot[30:0], 1'b1};
      end else begin
        nxt.rem  = r2[9:0];
        nxt.quot = {nxt.quot[30:0], 1'b0};
      end
    end
    return nxt;
  endfunction

  div_t              dv_in;
  div_t              dv [DIV_STAGES];
  logic [9:0]        dd [DIV_STAGES];
  logic [31:0]       phase;
  logic [31:0]       turn;
  logic signed [32:0] cx [CORDIC_STEPS+1];
  logic signed [32:0] cy [CORDIC_STEPS+1];
  logic signed [31:0] cz [CORDIC_STEPS+1];
  logic [1:0]        cq [CORDIC_STEPS+1];

  // Dividend is num * 2^32 + den / 2
  always_comb begin
    dv_in.rem  = '0;
    dv_in.bits = {3'b000, num, 23'b0, den[9:1]};
    dv_in.quot = '0;
  end

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    if (s == 0) begin : g_first
      always_ff @(posedge clk) begin
        dv[s] <= div_step(dv_in, den);
        dd[s] <= den;
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        dv[s] <= div_step(dv[s-1], dd[s-1]);
        dd[s] <= dd[s-1];
      end
    end
  end

  assign phase = dv[DIV_STAGES-1].quot;
  assign turn = phase + 32'h2000_0000;

  // Split into quadrant and a residual within an eighth of a turn
  always_ff @(posedge clk) begin
    cx[0] <= CORDIC_GAIN;
    cy[0] <= '0;
    cz[0] <= 32'({2'b00, turn[29:0]}) - 32'sh2000_0000;
    cq[0] <= turn[31:30];
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (!cz[k][31]) begin
        cx[k+1] <= cx[k] - (cy[k] >>> k);
        cy[k+1] <= cy[k] + (cx[k] >>> k);
        cz[k+1] <= cz[k] - ATAN_TURNS[k];
      end else begin
        cx[k+1] <= cx[k] + (cy[k] >>> k);
        cy[k+1] <= cy[k] - (cx[k] >>> k);
        cz[k+1] <= cz[k] + ATAN_TURNS[k];
      end
      cq[k+1] <= cq[k];
    end
  end

  always_ff @(posedge clk) begin
    unique case (cq[CORDIC_STEPS])
      2'd0: begin
        cos_val <= cx[CORDIC_STEPS];
        sin_val <= cy[CORDIC_STEPS];
      end
      2'd1: begin
        cos_val <= -cy[CORDIC_STEPS];
        sin_val <= cx[CORDIC_STEPS];
      end
      2'd2: begin
        cos_val <= -cx[CORDIC_STEPS];
        sin_val <= -cy[CORDIC_STEPS];
      end
      default: begin
        cos_val <= cy[CORDIC_STEPS];
        sin_val <= -cx[CORDIC_STEPS];
      end
    endcase
  end

endmodule

// ===== rtl/uvsg_back.sv =====
// Back end: corner sequencer, two angle lanes, products, rounding and output.
module uvsg_back (
  input  logic                   clk,
  input  logic                   rst,
  input  uvsg_pkg::item_t        head,
  input  logic                   head_valid,
  output logic                   pop,
  output logic                   done,
  output logic signed [15:0]     pos_x,
  output logic signed [15:0]     pos_y,
  output logic signed [15:0]     pos_z,
  output logic                   shade_positive,
  output logic [17:0]            vertex_number,
  output logic [1:0]             corner,
  output logic                   index_error,
  output logic                   last
);
  import uvsg_pkg::*;

  logic [1:0]         cnt;
  logic               step_u;
  logic               step_v;
  logic [8:0]         num_u;
  logic [8:0]         num_v;
  meta_t              issue_meta;
  meta_t              meta [PIPE_LAT];
  logic               vld [PIPE_LAT];
  logic signed [32:0] cu;
  logic signed [32:0] su;
  logic signed [32:0] cv;
  logic signed [32:0] sv;
  logic signed [65:0] px_p;
  logic signed [65:0] py_p;
  logic signed [32:0] cv_d;
  logic signed [65:0] px_r;
  logic signed [65:0] py_r;
  logic signed [32:0] pz_r;

  // Corner order (i,j) (i,j+1) (i+1,j+1) (i+1,j)
  assign step_u = cnt[1];
  assign step_v = cnt[1] ^ cnt[0];
  assign num_u = {1'b0, head.i} + 9'(step_u);
  assign num_v = {1'b0, head.j} + 9'(step_v);
  assign pop = head_valid && (cnt == 2'd3);

  always_comb begin
    issue_meta.shade  = head.shade;
    issue_meta.vnum   = {head.vbase, cnt};
    issue_meta.corner = cnt;
    issue_meta.err    = head.err;
    issue_meta.last   = (cnt == 2'd3);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (head_valid) begin
      cnt <= cnt + 1'b1;
    end
  end

  uvsg_lane u_lane_u (
    .clk     (clk),
    .num     (num_u),
    .den     ({1'b0, head.uc}),
    .cos_val (cu),
    .sin_val (su)
  );

  uvsg_lane u_lane_v (
    .clk     (clk),
    .num     (num_v),
    .den     ({head.vc, 1'b0}),
    .cos_val (cv),
    .sin_val (sv)
  );

  // Carry each vertex's tag alongside the lanes
  always_ff @(posedge clk) begin
    meta[0] <= issue_meta;
    for (int s = 1; s < PIPE_LAT; s++) meta[s] <= meta[s-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < PIPE_LAT; s++) vld[s] <= 1'b0;
    end else begin
      vld[0] <= head_valid;
      for (int s = 1; s < PIPE_LAT; s++) vld[s] <= vld[s-1];
    end
  end

  always_ff @(posedge clk) begin
    px_p <= cu * sv;
    py_p <= su * sv;
    cv_d <= cv;
  end

  // Round to nearest, ties up
  always_comb begin
    px_r = px_p + (66'sd1 <<< 45);
    py_r = py_p + (66'sd1 <<< 45);
    pz_r = cv_d + 33'sd32768;
  end

  always_ff @(posedge clk) begin
    pos_x <= sat_q14(px_r[65:46]);
    pos_y <= sat_q14(py_r[65:46]);
    pos_z <= sat_q14({{3{pz_r[32]}}, pz_r[32:16]});
  end

  assign done           = vld[PIPE_LAT-1];
  assign shade_positive = meta[PIPE_LAT-1].shade;
  assign vertex_number  = meta[PIPE_LAT-1].vnum;
  assign corner         = meta[PIPE_LAT-1].corner;
  assign index_error    = meta[PIPE_LAT-1].err;
  assign last           = meta[PIPE_LAT-1].last;

endmodule

// ===== rtl/uv_sphere_quad_generator.sv =====
// Top level of the UV sphere quad generator.
//
//  channel   | handshake                    | payload
//  ----------+------------------------------+-------------------------------------
//  request   | start / busy                 | u_index, v_index
//  config    | cfg_valid / cfg_ready        | cfg_index, cfg_data
//  vertex    | done (one cycle, no stall)   | pos_x/y/z, shade_positive,
//            |                              | vertex_number, corner, index_error, last
//
// Each request gives four vertex words on consecutive cycles; the corner
// sequencer issues one vertex a cycle while a request waits in the queue, and
// the back end takes the next request only after the last corner of the
// current one. A vertex passes the phase divider, CORDIC, product and rounding.
// A two-word queue lets the front take requests while the back end works; busy
// is high while the queue is full. Synchronous reset restores both segment
// counts to 16 and empties the queue and pipeline.
module uv_sphere_quad_generator #(
  parameter int MAX_U_SEGMENTS = 256,
  parameter int MAX_V_SEGMENTS = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [7:0]         u_index,
  input  logic [7:0]         v_index,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [8:0]         cfg_data,
  output logic               done,
  output logic signed [15:0] pos_x,
  output logic signed [15:0] pos_y,
  output logic signed [15:0] pos_z,
  output logic               shade_positive,
  output logic [17:0]        vertex_number,
  output logic [1:0]         corner,
  output logic               index_error,
  output logic               last
);
  import uvsg_pkg::*;

  item_t push_word;
  item_t head;
  logic  push;
  logic  pop;
  logic  head_valid;
  logic  full;

  assign busy = full;
  assign cfg_ready = 1'b1;

  uvsg_front #(
    .MAX_U_SEGMENTS (MAX_U_SEGMENTS),
    .MAX_V_SEGMENTS (MAX_V_SEGMENTS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .u_index   (u_index),
    .v_index   (v_index),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .full      (full),
    .push      (push),
    .word      (push_word)
  );

  uvsg_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_word  (push_word),
    .pop      (pop),
    .rd_word  (head),
    .nonempty (head_valid),
    .full     (full)
  );

  uvsg_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head           (head),
    .head_valid     (head_valid),
    .pop            (pop),
    .done           (done),
    .pos_x          (pos_x),
    .pos_y          (pos_y),
    .pos_z          (pos_z),
    .shade_positive (shade_positive),
    .vertex_number  (vertex_number),
    .corner         (corner),
    .index_error    (index_error),
    .last           (last)
  );

`ifndef SYNTH
  a_burst: assert property (@(posedge clk) disable iff (rst)
    done && !last |=> done && (corner == $past(corner) + 2'd1))
    else $error("vertex burst broken");

  a_last: assert property (@(posedge clk) disable iff (rst)
    done |-> (last == (corner == 2'd3)))
    else $error("last flag out of step with corner");

  a_next_quad: assert property (@(posedge clk) disable iff (rst)
    done && last |=> !done || corner == 2'd0)
    else $error("new quad does not open at its first corner");

  a_vnum: assert property (@(posedge clk) disable iff (rst)
    done && !last |=> vertex_number[17:2] == $past(vertex_number[17:2]))
    else $error("vertex number base changed within a quad");
`endif

endmodule
